FILE: hw/rtl/vertex_transform_perspective_divide_top_defines.svh
// assertion macros for the vertex transform block
`ifndef VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_TOP_DEFINES_SVH
`define VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define VTPD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vtpd check failed");

// next-cycle implication, checked outside reset
`define VTPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vtpd check failed");

`endif

FILE: hw/rtl/vtpd_pkg.sv
// shared types and constants for the vertex transform block
package vtpd_pkg;

  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = 3;
  localparam int DIV_STEPS = 33;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_WZERO = 2'd1,
    STATUS_SAT   = 2'd2
  } vtpd_status_t;

  typedef struct packed {
    logic valid;
    logic wzero;
  } vtpd_tag_t;

endpackage

FILE: hw/rtl/vtpd_div_lane.sv
// pipelined fixed-point divider lane, one quotient bit per stage
module vtpd_div_lane import vtpd_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  vtpd_tag_t          in_tag,
  input  logic [63:0]        nmag,
  input  logic [63:0]        wmag,
  input  logic               neg,
  output vtpd_tag_t          out_tag,
  output logic signed [31:0] quot,
  output logic               sat
);

  localparam int PRE_SHIFT = DIV_STEPS - FRAC_BITS;

  vtpd_tag_t              tag_p [DIV_STEPS+1];
  logic [63:0]            rem_p [DIV_STEPS+1];
  logic [63:0]            div_p [DIV_STEPS+1];
  logic [DIV_STEPS-1:0]   dig_p [DIV_STEPS+1];
  logic                   neg_p [DIV_STEPS+1];
  logic                   ovf_p [DIV_STEPS+1];
  logic [63:0]            pre;
  logic [DIV_STEPS-1:0]   qmag;
  logic                   sat_n;
  logic signed [31:0]     quot_next;

  // setup: overflow check and initial remainder
  assign pre = nmag >> PRE_SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_p[0] <= '0;
    end else if (adv) begin
      tag_p[0] <= in_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_p[0] <= pre;
      div_p[0] <= wmag;
      dig_p[0] <= DIV_STEPS'(nmag << FRAC_BITS);
      neg_p[0] <= neg;
      ovf_p[0] <= (pre >= wmag);
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [64:0] trial;
    logic        ge;

    assign trial = {rem_p[k], dig_p[k][DIV_STEPS-1]};
    assign ge    = (trial >= {1'b0, div_p[k]});

    always_ff @(posedge clk) begin
      if (rst) begin
        tag_p[k+1] <= '0;
      end else if (adv) begin
        tag_p[k+1] <= tag_p[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_p[k+1] <= ge ? 64'(trial - {1'b0, div_p[k]}) : 64'(trial);
        div_p[k+1] <= div_p[k];
        dig_p[k+1] <= {dig_p[k][DIV_STEPS-2:0], ge};
        neg_p[k+1] <= neg_p[k];
        ovf_p[k+1] <= ovf_p[k];
      end
    end
  end

  assign qmag = dig_p[DIV_STEPS];

  always_comb begin
    if (neg_p[DIV_STEPS]) begin
      sat_n = ovf_p[DIV_STEPS] || (qmag > DIV_STEPS'(33'h080000000));
    end else begin
      sat_n = ovf_p[DIV_STEPS] || (qmag > DIV_STEPS'(33'h07FFFFFFF));
    end
    if (tag_p[DIV_STEPS].wzero) begin
      quot_next = '0;
    end else if (sat_n) begin
      quot_next = neg_p[DIV_STEPS] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end else if (neg_p[DIV_STEPS]) begin
      quot_next = signed'(32'(-qmag[31:0]));
    end else begin
      quot_next = signed'(qmag[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_tag <= '0;
    end else if (adv) begin
      out_tag <= tag_p[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      quot <= quot_next;
      sat  <= sat_n && !tag_p[DIV_STEPS].wzero;
    end
  end

endmodule

FILE: hw/rtl/vertex_transform_perspective_divide_top.sv
// top level: 4x4 homogeneous vertex transform with perspective divide
//
// input channel: in_x, in_y, in_z with in_valid / in_stall; a request is
// taken when in_valid is high and in_stall is low
// output channel: out_x, out_y, out_z, status with out_valid / out_stall
// config channel: cfg_valid / cfg_ready, cfg_index selects one of eight
// 64-bit matrix registers, two entries each, low half first; cfg_ready
// is always high, write only while the pipeline is empty
// pipeline: multiply, sum, magnitude, divider setup, 33 divider bit
// stages, output register; the 33 bit stages of the three divider lanes
// set the depth
// throughput: one request per cycle unless stalled, fully pipelined
// stall: when out_valid is high and out_stall is high the whole pipeline
// holds and in_stall rises; nothing is lost or repeated
// reset: matrix returns to identity, all valid bits clear
// status: 0 ok, 1 w was zero (outputs zero), 2 a component saturated
module vertex_transform_perspective_divide_top import vtpd_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [31:0]   in_x,
  input  logic signed [31:0]   in_y,
  input  logic signed [31:0]   in_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   out_x,
  output logic signed [31:0]   out_y,
  output logic signed [31:0]   out_z,
  output logic [1:0]           status,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  `include "vertex_transform_perspective_divide_top_defines.svh"

  localparam logic [63:0] ONE_LO = 64'(1) << FRAC_BITS;
  localparam logic [63:0] ONE_HI = ONE_LO << 32;

  logic [63:0]        mat [NUM_REGS];
  logic signed [31:0] ent [16];
  logic               adv;

  logic               v1;
  logic signed [63:0] prod [4][3];
  logic signed [31:0] cterm [4];
  logic               v2;
  logic signed [65:0] sum [4];
  logic               v3;
  logic               neg [4];
  logic [63:0]        mag [4];
  logic               wzero;

  vtpd_tag_t          tag3;
  vtpd_tag_t          tag_out;
  logic               sat_x;
  logic               sat_y;
  logic               sat_z;

  assign cfg_ready = 1'b1;
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        mat[i] <= '0;
      end
      mat[0] <= ONE_LO;
      mat[2] <= ONE_HI;
      mat[5] <= ONE_LO;
      mat[7] <= ONE_HI;
    end else if (cfg_valid && cfg_ready) begin
      mat[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      ent[k] = signed'(mat[k/2][32*(k%2) +: 32]);
    end
  end

  // stage 1: products
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 4; r++) begin
        prod[r][0] <= 64'(in_x * ent[4*r]);
        prod[r][1] <= 64'(in_y * ent[4*r+1]);
        prod[r][2] <= 64'(in_z * ent[4*r+2]);
        cterm[r]   <= ent[4*r+3];
      end
    end
  end

  // stage 2: row sums
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 4; r++) begin
        sum[r] <= 66'(prod[r][0]) + 66'(prod[r][1]) + 66'(prod[r][2])
                + (66'(cterm[r]) <<< FRAC_BITS);
      end
    end
  end

  // stage 3: sign and magnitude
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 4; r++) begin
        neg[r] <= sum[r][65];
        mag[r] <= sum[r][65] ? 64'(-sum[r]) : 64'(sum[r]);
      end
      wzero <= (sum[3] == '0);
    end
  end

  assign tag3 = '{valid: v3, wzero: wzero};

  vtpd_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_tag  (tag3),
    .nmag    (mag[0]),
    .wmag    (mag[3]),
    .neg     ((neg[0] != neg[3]) && (mag[0] != '0)),
    .out_tag (tag_out),
    .quot    (out_x),
    .sat     (sat_x)
  );

  vtpd_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_tag  (tag3),
    .nmag    (mag[1]),
    .wmag    (mag[3]),
    .neg     ((neg[1] != neg[3]) && (mag[1] != '0)),
    .out_tag (),
    .quot    (out_y),
    .sat     (sat_y)
  );

  vtpd_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_tag  (tag3),
    .nmag    (mag[2]),
    .wmag    (mag[3]),
    .neg     ((neg[2] != neg[3]) && (mag[2] != '0)),
    .out_tag (),
    .quot    (out_z),
    .sat     (sat_z)
  );

  assign out_valid = tag_out.valid;

  always_comb begin
    if (tag_out.wzero) begin
      status = STATUS_WZERO;
    end else if (sat_x || sat_y || sat_z) begin
      status = STATUS_SAT;
    end else begin
      status = STATUS_OK;
    end
  end

  `VTPD_ASSERT_NOW(a_wzero_outputs_zero,
    out_valid && (status == STATUS_WZERO),
    (out_x == '0) && (out_y == '0) && (out_z == '0))
  `VTPD_ASSERT_NOW(a_status_legal, out_valid,
    (status == STATUS_OK) || (status == STATUS_WZERO) || (status == STATUS_SAT))
  `VTPD_ASSERT_NEXT(a_hold_on_stall, out_valid && out_stall,
    out_valid && $stable(status) && in_stall == out_stall)

endmodule
